// ===== rtl/iir_bp4_pkg.sv =====
// Shared types, widths and coefficient reset values for the order-4 band-pass IIR.
`timescale 1ns / 1ps

package iir_bp4_pkg;

    // Field and arithmetic widths.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int FEED_W   = SAMPLE_W + COEF_W;     // b*x product, Q.43
    localparam int BACK_W   = 2 * COEF_W;            // a*y product, Q.56
    localparam int BACK_SH  = 13;                    // Q.56 to Q.43
    localparam int ACC_W    = 56;                    // holds the Q.43 sum with margin
    localparam int Y_SH     = 15;                    // Q.43 to Q4.28
    localparam int S_SH     = 13;                    // Q4.28 to Q1.15
    localparam int CFG_IDX_W = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_word_t;

    // All filter coefficients, Q4.28 signed.
    typedef struct packed {
        coef_word_t b0;
        coef_word_t b2;
        coef_word_t b4;
        coef_word_t a1;
        coef_word_t a2;
        coef_word_t a3;
        coef_word_t a4;
    } coef_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B2 = 3'd1,
        REG_B4 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4,
        REG_A3 = 3'd5,
        REG_A4 = 3'd6
    } cfg_index_t;

    // Reset coefficient set.
    localparam coef_word_t B0_RESET = 32'sd322123;
    localparam coef_word_t B2_RESET = -32'sd644245;
    localparam coef_word_t B4_RESET = 32'sd322123;
    localparam coef_word_t A1_RESET = -32'sd961025776;
    localparam coef_word_t A2_RESET = 32'sd1307898072;
    localparam coef_word_t A3_RESET = -32'sd804259470;
    localparam coef_word_t A4_RESET = 32'sd189032248;

endpackage

// ===== rtl/iir_bp4_coef_regs.sv =====
// Configuration register file holding the seven filter coefficients.
`timescale 1ns / 1ps

module iir_bp4_coef_regs
    import iir_bp4_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    output coef_t                coef
);

    coef_t coef_reg;
    coef_t coef_next;

    // The register file takes a write in every cycle.
    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    // Decode the index; a write to an unused index changes nothing.
    always_comb begin
        coef_next = coef_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_B0:  coef_next.b0 = cfg_data;
                REG_B2:  coef_next.b2 = cfg_data;
                REG_B4:  coef_next.b4 = cfg_data;
                REG_A1:  coef_next.a1 = cfg_data;
                REG_A2:  coef_next.a2 = cfg_data;
                REG_A3:  coef_next.a3 = cfg_data;
                REG_A4:  coef_next.a4 = cfg_data;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b0 <= B0_RESET;
            coef_reg.b2 <= B2_RESET;
            coef_reg.b4 <= B4_RESET;
            coef_reg.a1 <= A1_RESET;
            coef_reg.a2 <= A2_RESET;
            coef_reg.a3 <= A3_RESET;
            coef_reg.a4 <= A4_RESET;
        end else begin
            coef_reg <= coef_next;
        end
    end

endmodule

// ===== rtl/iir_bp4_datapath.sv =====
// Combinational filter arithmetic: products, sum, rounding and saturation.
`timescale 1ns / 1ps

module iir_bp4_datapath
    import iir_bp4_pkg::*;
(
    input  coef_t      coef,
    input  sample_t    x0,
    input  sample_t    x2,
    input  sample_t    x4,
    input  coef_word_t y1,
    input  coef_word_t y2,
    input  coef_word_t y3,
    input  coef_word_t y4,
    output coef_word_t y0,
    output sample_t    sample_out,
    output logic       clipped
);

    localparam int BT_W = BACK_W - BACK_SH;          // shifted back product width
    localparam int YW_W = ACC_W - Y_SH;              // rounded Q4.28 before clamp
    localparam int SW_W = COEF_W + 1 - S_SH;         // rounded Q1.15 before clamp

    logic signed [FEED_W-1:0] p_b0, p_b2, p_b4;
    logic signed [BACK_W-1:0] p_a1, p_a2, p_a3, p_a4;
    logic signed [BT_W-1:0]   t_a1, t_a2, t_a3, t_a4;
    logic signed [ACC_W-1:0]  acc, acc_rnd;
    logic signed [YW_W-1:0]   y_wide;
    logic signed [COEF_W:0]   y_ext, s_rnd;
    logic signed [SW_W-1:0]   s_wide;
    logic                     y_ovf, s_ovf;

    // Seven independent products.
    assign p_b0 = coef.b0 * x0;
    assign p_b2 = coef.b2 * x2;
    assign p_b4 = coef.b4 * x4;
    assign p_a1 = coef.a1 * y1;
    assign p_a2 = coef.a2 * y2;
    assign p_a3 = coef.a3 * y3;
    assign p_a4 = coef.a4 * y4;

    // Back products are floored down to the feed scale by dropping low bits.
    assign t_a1 = $signed(p_a1[BACK_W-1:BACK_SH]);
    assign t_a2 = $signed(p_a2[BACK_W-1:BACK_SH]);
    assign t_a3 = $signed(p_a3[BACK_W-1:BACK_SH]);
    assign t_a4 = $signed(p_a4[BACK_W-1:BACK_SH]);

    // Exact sum of all terms.
    assign acc = ACC_W'(p_b0) + ACC_W'(p_b2) + ACC_W'(p_b4)
               - ACC_W'(t_a1) - ACC_W'(t_a2) - ACC_W'(t_a3) - ACC_W'(t_a4);

    // Round half up to Q4.28 and clamp to the 32-bit range.
    assign acc_rnd = acc + (ACC_W'(1) <<< (Y_SH - 1));
    assign y_wide  = $signed(acc_rnd[ACC_W-1:Y_SH]);
    assign y_ovf   = (y_wide[YW_W-1:COEF_W-1] != {(YW_W-COEF_W+1){1'b0}}) &&
                     (y_wide[YW_W-1:COEF_W-1] != {(YW_W-COEF_W+1){1'b1}});

    always_comb begin
        if (y_ovf) begin
            y0 = y_wide[YW_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
            y0 = y_wide[COEF_W-1:0];
        end
    end

    // Round half up to Q1.15 and clamp to 16 bits.
    assign y_ext  = {y0[COEF_W-1], y0};
    assign s_rnd  = y_ext + ((COEF_W+1)'(1) <<< (S_SH - 1));
    assign s_wide = $signed(s_rnd[COEF_W:S_SH]);
    assign s_ovf  = (s_wide[SW_W-1:SAMPLE_W-1] != {(SW_W-SAMPLE_W+1){1'b0}}) &&
                    (s_wide[SW_W-1:SAMPLE_W-1] != {(SW_W-SAMPLE_W+1){1'b1}});

    always_comb begin
        if (s_ovf) begin
            sample_out = s_wide[SW_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            sample_out = s_wide[SAMPLE_W-1:0];
        end
    end

    assign clipped = y_ovf | s_ovf;

endmodule

// ===== rtl/iir_bandpass_order4_core.sv =====
// Top level of the fourth-order direct-form-I band-pass IIR filter.
//
// Usage:
//   Samples arrive on the s_ stream: s_tdata[15:0] is a signed Q1.15 sample,
//   s_tlast marks the last sample of a buffer. Each sample gives one result
//   on the m_ stream: m_tdata[15:0] is the filtered Q1.15 sample, m_tuser is
//   set when the stored history or the output sample saturated, and m_tlast
//   is the copied end-of-buffer marker.
//   Coefficients (Q4.28) are written on the cfg_ channel, index 0..6 in the
//   order b0, b2, b4, a1, a2, a3, a4; write them only while no sample is in
//   flight. cfg_ready is always high and index 7 is ignored.
//   A transferred sample fills the input register and moves on to the output
//   register when that is free. Throughput is one sample per cycle unless the
//   receiver stalls, set by the combinational recursion from the previous
//   output through the multipliers and the sum back into the output history.
//   A synchronous low aresetn empties both stages, clears the sample and
//   output history to zero and restores the default coefficient set.
//   When the receiver stalls, the result holds in the output register and
//   one more sample may wait in the input register; s_tready then drops.
`timescale 1ns / 1ps

module iir_bandpass_order4_core
    import iir_bp4_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream; s_tdata fields from bit 0: sample_in[15:0].
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic                 s_tlast,
    // Result stream; m_tdata fields from bit 0: sample_out[15:0].
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    // m_tuser fields from bit 0: clipped.
    output logic                 m_tuser,
    output logic                 m_tlast,
    // Coefficient write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    coef_t      coef;
    logic       in_valid_reg;
    sample_t    x0_reg;
    logic       last_in_reg;
    sample_t    x_hist_reg [4];
    coef_word_t y_hist_reg [4];
    logic       out_valid_reg;
    sample_t    sample_reg;
    logic       clip_reg;
    logic       last_out_reg;
    logic       out_free;
    logic       advance;
    coef_word_t y0;
    sample_t    sample_calc;
    logic       clip_calc;

    iir_bp4_coef_regs u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    iir_bp4_datapath u_datapath (
        .coef       (coef),
        .x0         (x0_reg),
        .x2         (x_hist_reg[1]),
        .x4         (x_hist_reg[3]),
        .y1         (y_hist_reg[0]),
        .y2         (y_hist_reg[1]),
        .y3         (y_hist_reg[2]),
        .y4         (y_hist_reg[3]),
        .y0         (y0),
        .sample_out (sample_calc),
        .clipped    (clip_calc)
    );

    // Stage control: the output register frees when empty or taken.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sample_reg;
    assign m_tuser  = clip_reg;
    assign m_tlast  = last_out_reg;

    // Input register: loads on every transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x0_reg      <= s_tdata;
            last_in_reg <= s_tlast;
        end
    end

    // Sample and output history shift when a sample moves to the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end else if (advance) begin
            for (int i = 3; i > 0; i--) begin
                x_hist_reg[i] <= x_hist_reg[i-1];
                y_hist_reg[i] <= y_hist_reg[i-1];
            end
            x_hist_reg[0] <= x0_reg;
            y_hist_reg[0] <= y0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sample_reg   <= sample_calc;
            clip_reg     <= clip_calc;
            last_out_reg <= last_in_reg;
        end
    end

endmodule

// ===== rtl/iir_bp4_checker.sv =====
// Port-level checks on the band-pass IIR core, bound to the top level.
`timescale 1ns / 1ps

module iir_bp4_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // A fresh result follows an earlier input transfer: the transfer fills the
    // input register, from which the sample then moves to the output register.
    a_rise_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding input transfer");

    // With the output stage empty the input side never blocks.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    // Any clipping drives the emitted sample to a rail.
    a_clip_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
        else $error("clip flag with a sample off the rails");

endmodule

bind iir_bandpass_order4_core iir_bp4_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_iir_bandpass_order4_core.sv =====
// Self-checking testbench for the order-4 band-pass IIR core.
`timescale 1ns / 1ps

module tb_iir_bandpass_order4_core;
    import iir_bp4_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT = 34;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam longint HIST_MAX = 64'sd2147483647;
    localparam longint HIST_MIN = -64'sd2147483648;
    localparam longint OUT_MAX = 64'sd32767;
    localparam longint OUT_MIN = -64'sd32768;
    localparam coef_word_t COEF_MAX = 32'sh7FFF_FFFF;
    localparam coef_word_t COEF_MIN = 32'sh8000_0000;
    localparam coef_word_t COEF_ONE = 32'sh1000_0000;

    typedef struct packed {
        sample_t sample;
        logic    block_end;
    } audio_in_t;

    typedef struct packed {
        sample_t sample;
        logic    clipped;
        logic    block_end;
    } filtered_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0] cfg_data = '0;

    // Stimulus and prediction state.
    audio_in_t pending_samples[$];
    filtered_t predicted_out[$];
    audio_in_t next_in;
    filtered_t want;
    coef_t coefs;
    sample_t x_hist[4];
    int y_hist[4];
    int queued_total = 0;
    int accepted_total = 0;
    int errors = 0;
    int cycle_count = 0;
    bit in_taken = 1'b0;
    bit steady = 1'b0;

    iir_bandpass_order4_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // One filter step: computes the expected result and shifts the history.
    function automatic void filter_sample(sample_t x0, logic last);
        longint acc;
        longint y;
        longint s;
        bit clip;
        filtered_t res;
        clip = 1'b0;
        acc = longint'($signed(coefs.b0)) * longint'(x0)
            + longint'($signed(coefs.b2)) * longint'(x_hist[1])
            + longint'($signed(coefs.b4)) * longint'(x_hist[3]);
        // Feedback products are floored down to the feed scale before the sum.
        acc -= (longint'($signed(coefs.a1)) * longint'(y_hist[0])) >>> BACK_SH;
        acc -= (longint'($signed(coefs.a2)) * longint'(y_hist[1])) >>> BACK_SH;
        acc -= (longint'($signed(coefs.a3)) * longint'(y_hist[2])) >>> BACK_SH;
        acc -= (longint'($signed(coefs.a4)) * longint'(y_hist[3])) >>> BACK_SH;
        y = (acc + 64'sd16384) >>> Y_SH;
        if (y > HIST_MAX) begin
            y = HIST_MAX;
            clip = 1'b1;
        end
        if (y < HIST_MIN) begin
            y = HIST_MIN;
            clip = 1'b1;
        end
        s = (y + 64'sd4096) >>> S_SH;
        if (s > OUT_MAX) begin
            s = OUT_MAX;
            clip = 1'b1;
        end
        if (s < OUT_MIN) begin
            s = OUT_MIN;
            clip = 1'b1;
        end
        for (int i = 3; i > 0; i--) begin
            x_hist[i] = x_hist[i-1];
            y_hist[i] = y_hist[i-1];
        end
        x_hist[0] = x0;
        y_hist[0] = int'(y);
        res.sample = s[15:0];
        res.clipped = clip;
        res.block_end = last;
        predicted_out.push_back(res);
    endfunction

    // Writes one coefficient register and mirrors it once the transfer is done.
    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_word_t value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_B0: coefs.b0 = value;
            REG_B2: coefs.b2 = value;
            REG_B4: coefs.b4 = value;
            REG_A1: coefs.a1 = value;
            REG_A2: coefs.a2 = value;
            REG_A3: coefs.a3 = value;
            REG_A4: coefs.a4 = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_set(input coef_t c);
        write_coef(REG_B0, c.b0);
        write_coef(REG_B2, c.b2);
        write_coef(REG_B4, c.b4);
        write_coef(REG_A1, c.a1);
        write_coef(REG_A2, c.a2);
        write_coef(REG_A3, c.a3);
        write_coef(REG_A4, c.a4);
    endtask

    task automatic queue_sample(input sample_t v, input logic last);
        pending_samples.push_back('{v, last});
        queued_total++;
    endtask

    // Mostly full-range samples, with extremes and small values mixed in.
    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return sample_t'(int'($urandom_range(512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            queue_sample(pick_sample(), $urandom_range(7) == 0);
        end
    endtask

    function automatic coef_word_t mild_coef();
        return coef_word_t'(int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
    endfunction

    // Waits until every sample went in and every result came out.
    task automatic drain();
        while (accepted_total != queued_total || predicted_out.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Input driver: presents the next pending sample once the last one transferred.
    always @(negedge aclk) begin
        if (!s_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (pending_samples.size() != 0 && !idle_now()) begin
                next_in = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_in.sample;
                s_tlast <= next_in.block_end;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure.
    always @(negedge aclk) begin
        m_tready <= !idle_now();
    end

    // Monitor: predicts on input transfers and checks result transfers.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (predicted_out.size() == 0) begin
                    $error("unexpected result: sample_out %0d", $signed(m_tdata));
                    errors++;
                end else begin
                    want = predicted_out.pop_front();
                    if (m_tdata !== want.sample) begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(want.sample), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser !== want.clipped) begin
                        $error("clipped: expected %0b, got %0b", want.clipped, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.block_end) begin
                        $error("block_end_out: expected %0b, got %0b",
                               want.block_end, m_tlast);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                filter_sample(sample_t'(s_tdata), s_tlast);
                accepted_total++;
                in_taken = 1'b1;
            end
        end
    end

    // Stimulus sequence, one coefficient setting per phase.
    initial begin
        coef_t c;
        coefs = '{B0_RESET, B2_RESET, B4_RESET, A1_RESET, A2_RESET, A3_RESET, A4_RESET};
        for (int i = 0; i < 4; i++) begin
            x_hist[i] = '0;
            y_hist[i] = 0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default coefficients: field extremes and buffer markers.
        queue_sample(16'sh0000, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh0001, 1'b0);
        queue_sample(16'shFFFF, 1'b1);
        queue_sample(16'sh5555, 1'b0);
        queue_sample(16'shAAAA, 1'b0);
        queue_sample(16'sh0000, 1'b1);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(16'sh0000, 1'b0);
        queue_random(60);
        drain();

        // Unity pass-through with no idling; the spare index must not disturb it.
        steady = 1'b1;
        write_set('{COEF_ONE, '0, '0, '0, '0, '0, '0});
        write_coef(CFG_SPARE_IDX, coef_word_t'($urandom));
        queue_random(100);
        drain();
        steady = 1'b0;

        // Largest positive gains: history and output saturate both ways.
        write_set('{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX});
        for (int i = 0; i < 4; i++) queue_sample(16'sh7FFF, 1'b0);
        for (int i = 0; i < 4; i++) queue_sample(16'sh8000, i == 3);
        queue_random(60);
        drain();

        // Most negative gains.
        write_set('{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN});
        queue_random(60);
        drain();

        // Negative feed gain alone, no feedback.
        write_set('{COEF_MIN, '0, '0, '0, '0, '0, '0});
        queue_random(50);
        drain();

        // Back to the default band-pass set.
        write_set('{B0_RESET, B2_RESET, B4_RESET, A1_RESET, A2_RESET, A3_RESET, A4_RESET});
        queue_random(100);
        drain();

        // Random mild coefficient sets.
        for (int p = 0; p < 2; p++) begin
            c = '{mild_coef(), mild_coef(), mild_coef(), mild_coef(),
                  mild_coef(), mild_coef(), mild_coef()};
            write_set(c);
            queue_random(80);
            drain();
        end

        // Random full-range coefficient sets.
        for (int p = 0; p < 2; p++) begin
            c = '{coef_word_t'($urandom), coef_word_t'($urandom), coef_word_t'($urandom),
                  coef_word_t'($urandom), coef_word_t'($urandom), coef_word_t'($urandom),
                  coef_word_t'($urandom)};
            write_set(c);
            queue_random(50);
            drain();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0 && predicted_out.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
